[src/lrrc_pkg.sv]
// Shared types, constants and the CRC byte update for the log record checker.
package lrrc_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAGIC_VALUE  = 2'd0;
  localparam logic [1:0] CFG_KEY_WIDE     = 2'd1;
  localparam logic [1:0] CFG_RECORD_BYTES = 2'd2;

  // Result status codes
  localparam logic [2:0] STATUS_GOOD      = 3'd0;
  localparam logic [2:0] STATUS_BAD_MAGIC = 3'd1;
  localparam logic [2:0] STATUS_CRC_ERROR = 3'd2;
  localparam logic [2:0] STATUS_TORN_TAIL = 3'd3;
  localparam logic [2:0] STATUS_CLEAN_END = 3'd4;

  // Record layout, in bytes
  localparam logic [6:0] HEADER_BYTES    = 7'd2;
  localparam logic [6:0] KEY_NARROW_LEN  = 7'd8;
  localparam logic [6:0] KEY_WIDE_LEN    = 7'd16;
  localparam logic [6:0] ADDRESS_BYTES   = 7'd8;
  localparam logic [6:0] CRC_BYTES       = 7'd4;
  localparam logic [6:0] RECORD_RESET    = 7'd32;

  // CRC-32, reflected form
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  localparam logic [47:0] OFFSET_MAX = 48'hFFFF_FFFF_FFFF;

  // Queue between the front and back parts
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] log_byte;
    logic       log_end;
  } log_item_t;

  typedef struct packed {
    logic [2:0]  record_status;
    logic [7:0]  record_type;
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [63:0] disk_address;
    logic [63:0] old_disk_address;
    logic [47:0] good_offset;
  } rec_item_t;

  typedef struct packed {
    logic       is_end;
    logic [7:0] data;
  } q_entry_t;

  typedef struct packed {
    logic [7:0] magic_value;
    logic       key_wide;
    logic [6:0] record_bytes;
  } cfg_t;

  // Advance the CRC by one byte, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'b0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[src/log_record_replay_checker.sv]
// A result is registered when the back part pops the item that ends it. Throughput: one
// log item per cycle while the queue has room; the back stage's per-byte CRC update and
// field capture retire one queued item each cycle while the result register is free or
// taken. Reset clears the queue, record position, halt flag, good offset and result
// valid, and returns the registers to magic 0, narrow keys and a 32-byte record.
module log_record_replay_checker #(
  parameter int MAX_RECORD_BYTES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                log_valid,
  output logic                log_ready,
  input  lrrc_pkg::log_item_t log_item,
  output logic                rec_valid,
  input  logic                rec_ready,
  output lrrc_pkg::rec_item_t rec_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  lrrc_pkg::cfg_t     cfg;
  logic               q_valid;
  lrrc_pkg::q_entry_t q_head;
  logic               q_pop;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_value  <= 8'h00;
      cfg.key_wide     <= 1'b0;
      cfg.record_bytes <= lrrc_pkg::RECORD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lrrc_pkg::CFG_MAGIC_VALUE:  cfg.magic_value  <= cfg_data;
        lrrc_pkg::CFG_KEY_WIDE:     cfg.key_wide     <= cfg_data[0];
        lrrc_pkg::CFG_RECORD_BYTES: cfg.record_bytes <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  lrrc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .log_valid (log_valid),
    .log_ready (log_ready),
    .log_item  (log_item),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  lrrc_back #(
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec_item  (rec_item)
  );

endmodule

[src/lrrc_front.sv]
// Front part: accepts log items, tags end markers and queues them for the back part.
module lrrc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                log_valid,
  output logic                log_ready,
  input  lrrc_pkg::log_item_t log_item,
  output logic                q_valid,
  output lrrc_pkg::q_entry_t  q_head,
  input  logic                q_pop
);

  logic [lrrc_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [lrrc_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [lrrc_pkg::QUEUE_CNT_W-1:0] count;
  logic [lrrc_pkg::QUEUE_CNT_W-1:0] count_next;
  lrrc_pkg::q_entry_t               slots [lrrc_pkg::QUEUE_DEPTH];
  lrrc_pkg::q_entry_t               entry;
  logic                             push;

  assign log_ready = (count != lrrc_pkg::QUEUE_CNT_W'(lrrc_pkg::QUEUE_DEPTH));
  assign push      = log_valid && log_ready;
  assign q_valid   = (count != '0);
  assign q_head    = slots[rd_ptr];

  // Classify: an end marker carries no byte
  always_comb begin
    entry.is_end = log_item.log_end;
    entry.data   = log_item.log_end ? 8'h00 : log_item.log_byte;
  end

  // Track occupancy
  always_comb begin
    case ({push, q_pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  // Store the transfer
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

endmodule

[src/lrrc_back.sv]
// Back part: byte capture, CRC check, offset tracking and the result register.
module lrrc_back #(
  parameter int MAX_RECORD_BYTES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  lrrc_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  lrrc_pkg::q_entry_t  q_head,
  output logic                q_pop,
  output logic                rec_valid,
  input  logic                rec_ready,
  output lrrc_pkg::rec_item_t rec_item
);

  localparam int         POS_W    = $clog2(MAX_RECORD_BYTES);
  localparam logic [6:0] MAX_SIZE = 7'(MAX_RECORD_BYTES);

  // Record state
  logic [POS_W-1:0]  pos;
  logic [31:0]       running_crc;
  logic              magic_match;
  logic [7:0]        type_hold;
  logic [63:0]       key_low_hold;
  logic [63:0]       key_high_hold;
  logic [63:0]       address_hold;
  logic [63:0]       old_address_hold;
  logic [31:0]       stored_crc;
  logic              halted;
  logic [47:0]       offset_count;

  logic [POS_W-1:0]  pos_next;
  logic [31:0]       running_crc_next;
  logic              magic_match_next;
  logic [7:0]        type_hold_next;
  logic [63:0]       key_low_hold_next;
  logic [63:0]       key_high_hold_next;
  logic [63:0]       address_hold_next;
  logic [63:0]       old_address_hold_next;
  logic [31:0]       stored_crc_next;
  logic              halted_next;
  logic [47:0]       offset_count_next;
  logic              rec_valid_next;
  lrrc_pkg::rec_item_t rec_item_next;

  // Layout for the current key size
  logic [6:0]  key_len;
  logic [6:0]  key_end;
  logic [6:0]  addr_end;
  logic [6:0]  payload_end;
  logic [6:0]  crc_end;
  logic [6:0]  size;
  logic [6:0]  pos7;
  logic [6:0]  key_off;
  logic [6:0]  addr_off;
  logic [6:0]  old_off;
  logic [6:0]  crc_off;
  logic [63:0] byte_wide;
  logic        last;
  logic        crc_ok;
  logic [48:0] offset_sum;

  assign q_pop = q_valid && (!rec_valid || rec_ready);

  // Decode layout and effective record size
  always_comb begin
    key_len     = cfg.key_wide ? lrrc_pkg::KEY_WIDE_LEN : lrrc_pkg::KEY_NARROW_LEN;
    key_end     = lrrc_pkg::HEADER_BYTES + key_len;
    addr_end    = key_end + lrrc_pkg::ADDRESS_BYTES;
    payload_end = addr_end + lrrc_pkg::ADDRESS_BYTES;
    crc_end     = payload_end + lrrc_pkg::CRC_BYTES;
    size        = (cfg.record_bytes < crc_end) ? crc_end : cfg.record_bytes;
    if (size > MAX_SIZE) begin
      size = MAX_SIZE;
    end
    pos7      = 7'(pos);
    key_off   = pos7 - lrrc_pkg::HEADER_BYTES;
    addr_off  = pos7 - key_end;
    old_off   = pos7 - addr_end;
    crc_off   = pos7 - payload_end;
    byte_wide = {56'b0, q_head.data};
    last      = (pos7 + 7'd1) >= size;
  end

  // Next state and result
  always_comb begin
    pos_next              = pos;
    halted_next           = halted;
    offset_count_next     = offset_count;
    magic_match_next      = magic_match;
    // A new record starts from cleared holds
    if (pos == '0) begin
      running_crc_next      = lrrc_pkg::CRC_ONES;
      type_hold_next        = 8'h00;
      key_low_hold_next     = 64'h0;
      key_high_hold_next    = 64'h0;
      address_hold_next     = 64'h0;
      old_address_hold_next = 64'h0;
      stored_crc_next       = 32'h0;
    end else begin
      running_crc_next      = running_crc;
      type_hold_next        = type_hold;
      key_low_hold_next     = key_low_hold;
      key_high_hold_next    = key_high_hold;
      address_hold_next     = address_hold;
      old_address_hold_next = old_address_hold;
      stored_crc_next       = stored_crc;
    end
    rec_valid_next = rec_valid && !rec_ready;
    rec_item_next  = rec_item;
    crc_ok         = 1'b0;
    offset_sum     = 49'h0;

    if (q_pop) begin
      if (q_head.is_end) begin
        // Report end of log and rearm
        rec_valid_next                 = 1'b1;
        rec_item_next                  = '0;
        rec_item_next.record_status    = (pos != '0) ? lrrc_pkg::STATUS_TORN_TAIL
                                                     : lrrc_pkg::STATUS_CLEAN_END;
        rec_item_next.good_offset      = offset_count;
        pos_next                       = '0;
        halted_next                    = 1'b0;
        offset_count_next              = 48'h0;
        magic_match_next               = 1'b0;
      end else if (!halted) begin
        // Capture the byte into its field
        if (pos == '0) begin
          magic_match_next = (q_head.data == cfg.magic_value);
        end else if (pos7 == 7'd1) begin
          type_hold_next = q_head.data;
        end else if (pos7 < key_end) begin
          if (key_off < 7'd8) begin
            key_low_hold_next = key_low_hold_next | (byte_wide << {key_off[2:0], 3'b000});
          end else begin
            key_high_hold_next = key_high_hold_next | (byte_wide << {key_off[2:0], 3'b000});
          end
        end else if (pos7 < addr_end) begin
          address_hold_next = address_hold_next | (byte_wide << {addr_off[2:0], 3'b000});
        end else if (pos7 < payload_end) begin
          old_address_hold_next = old_address_hold_next | (byte_wide << {old_off[2:0], 3'b000});
        end else if (pos7 < crc_end) begin
          stored_crc_next = stored_crc_next | (byte_wide[31:0] << {crc_off[1:0], 3'b000});
        end
        if (pos7 < payload_end) begin
          running_crc_next = lrrc_pkg::crc_byte(running_crc_next, q_head.data);
        end

        if (last) begin
          // Check the record and report it
          crc_ok         = ((running_crc_next ^ lrrc_pkg::CRC_ONES) == stored_crc_next);
          offset_sum     = {1'b0, offset_count} + 49'(size);
          rec_valid_next = 1'b1;
          rec_item_next  = '0;
          pos_next       = '0;
          if (!magic_match_next) begin
            rec_item_next.record_status = lrrc_pkg::STATUS_BAD_MAGIC;
            rec_item_next.good_offset   = offset_count;
            halted_next                 = 1'b1;
          end else if (!crc_ok) begin
            rec_item_next.record_status = lrrc_pkg::STATUS_CRC_ERROR;
            rec_item_next.good_offset   = offset_count;
            halted_next                 = 1'b1;
          end else begin
            offset_count_next = offset_sum[48] ? lrrc_pkg::OFFSET_MAX : offset_sum[47:0];
            rec_item_next.record_status    = lrrc_pkg::STATUS_GOOD;
            rec_item_next.record_type      = type_hold_next;
            rec_item_next.key_low          = key_low_hold_next;
            rec_item_next.key_high         = key_high_hold_next;
            rec_item_next.disk_address     = address_hold_next;
            rec_item_next.old_disk_address = old_address_hold_next;
            rec_item_next.good_offset      = offset_count_next;
          end
        end else begin
          pos_next = pos + 1'b1;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      halted       <= 1'b0;
      offset_count <= 48'h0;
      magic_match  <= 1'b0;
      rec_valid    <= 1'b0;
    end else begin
      pos          <= pos_next;
      halted       <= halted_next;
      offset_count <= offset_count_next;
      magic_match  <= magic_match_next;
      rec_valid    <= rec_valid_next;
    end
  end

  // Field holds and result payload
  always_ff @(posedge clk) begin
    running_crc      <= running_crc_next;
    type_hold        <= type_hold_next;
    key_low_hold     <= key_low_hold_next;
    key_high_hold    <= key_high_hold_next;
    address_hold     <= address_hold_next;
    old_address_hold <= old_address_hold_next;
    stored_crc       <= stored_crc_next;
    rec_item         <= rec_item_next;
  end

endmodule
